FILE: sv/scale_weight_stability_display_macros.svh
// Assertion macros used by the file that checks this block.
`ifndef SCALE_WEIGHT_STABILITY_DISPLAY_MACROS_SVH
`define SCALE_WEIGHT_STABILITY_DISPLAY_MACROS_SVH

// Checked only while the block is out of reset.
`define SWSD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SWSD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/swsd_pkg.sv
`default_nettype none

package swsd_pkg;

    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] CFG_ZERO_OFFSET   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_TARE          = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_MIN_TRIGGER   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_STABLE_NEEDED = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_HYSTERESIS    = 3'd4;

    localparam logic [15:0] MIN_TRIGGER_RESET   = 16'd150;
    localparam logic [7:0]  STABLE_NEEDED_RESET = 8'd3;
    localparam logic [9:0]  HYSTERESIS_RESET    = 10'd7;

    localparam logic signed [23:0] NET_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] NET_MIN = 24'sh800000;

    localparam logic [23:0] DISP_LIMIT = 24'd8388600;
    localparam logic [24:0] RECIP10    = 25'd26843546;
    localparam int          RecipShift = 28;

    typedef struct packed {
        logic signed [23:0] zero_offset;
        logic signed [23:0] tare;
        logic [15:0]        min_trigger;
        logic [7:0]         stable_needed;
        logic [9:0]         hysteresis;
    } cfg_t;

    typedef struct packed {
        logic signed [23:0] net;
        logic               stable;
    } net_item_t;

    typedef struct packed {
        logic signed [23:0] net;
        logic signed [23:0] raw;
        logic signed [23:0] rnd;
        logic               above;
        logic               stable;
    } prep_item_t;

    typedef struct packed {
        logic signed [23:0] net_weight;
        logic signed [23:0] shown_weight;
        logic signed [23:0] display_weight;
        logic               stable;
        logic               stable_changed;
        logic               trigger;
        logic               weight_changed;
        logic               display_changed;
    } out_item_t;

endpackage

`default_nettype wire

FILE: sv/swsd_cfg.sv
`default_nettype none

module swsd_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           wr_en,
    input  wire logic [swsd_pkg::CfgIdxW-1:0]   wr_addr,
    input  wire logic [23:0]                    wr_data,
    output swsd_pkg::cfg_t                      cfg
);

    swsd_pkg::cfg_t cfg_reg;
    swsd_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_addr)
                swsd_pkg::CFG_ZERO_OFFSET:   cfg_next.zero_offset   = $signed(wr_data);
                swsd_pkg::CFG_TARE:          cfg_next.tare          = $signed(wr_data);
                swsd_pkg::CFG_MIN_TRIGGER:   cfg_next.min_trigger   = wr_data[15:0];
                swsd_pkg::CFG_STABLE_NEEDED: cfg_next.stable_needed = wr_data[7:0];
                swsd_pkg::CFG_HYSTERESIS:    cfg_next.hysteresis    = wr_data[9:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_offset   <= '0;
            cfg_reg.tare          <= '0;
            cfg_reg.min_trigger   <= swsd_pkg::MIN_TRIGGER_RESET;
            cfg_reg.stable_needed <= swsd_pkg::STABLE_NEEDED_RESET;
            cfg_reg.hysteresis    <= swsd_pkg::HYSTERESIS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: sv/swsd_net.sv
`default_nettype none

module swsd_net (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire swsd_pkg::cfg_t     cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [23:0] weight,
    input  wire logic               stable,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output swsd_pkg::net_item_t     out_item
);

    logic                valid_reg;
    logic                valid_next;
    swsd_pkg::net_item_t item_reg;
    swsd_pkg::net_item_t item_next;
    logic signed [25:0]  diff;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        diff = 26'(weight) - 26'(cfg.zero_offset) - 26'(cfg.tare);
        item_next.stable = stable;
        if (diff > 26'(swsd_pkg::NET_MAX)) begin
            item_next.net = swsd_pkg::NET_MAX;
        end else if (diff < 26'(swsd_pkg::NET_MIN)) begin
            item_next.net = swsd_pkg::NET_MIN;
        end else begin
            item_next.net = diff[23:0];
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

FILE: sv/swsd_round.sv
`default_nettype none

module swsd_round (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire swsd_pkg::cfg_t      cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire swsd_pkg::net_item_t in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output swsd_pkg::prep_item_t     out_item
);

    logic                 valid_reg;
    logic                 valid_next;
    swsd_pkg::prep_item_t item_reg;
    swsd_pkg::prep_item_t item_next;
    logic signed [23:0]   raw;
    logic [23:0]          abs_raw;
    logic [23:0]          abs_net;
    logic [24:0]          biased;
    logic [49:0]          prod;
    logic [19:0]          quot;
    logic [23:0]          mult10;
    logic [23:0]          clamped;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        // Small negative readings are shown as zero.
        if (in_item.net > -24'sd20 && in_item.net < 24'sd0) begin
            raw = '0;
        end else begin
            raw = in_item.net;
        end
        abs_raw = raw[23] ? (~raw + 24'd1) : raw;
        abs_net = in_item.net[23] ? (~in_item.net + 24'd1) : in_item.net;
        // Round half away from zero: (|raw| + 5) / 10 by reciprocal multiply.
        biased  = {1'b0, abs_raw} + 25'd5;
        prod    = 50'(biased) * 50'(swsd_pkg::RECIP10);
        quot    = prod[swsd_pkg::RecipShift +: 20];
        mult10  = 24'({quot, 3'b000}) + 24'({quot, 1'b0});
        clamped = (mult10 > swsd_pkg::DISP_LIMIT) ? swsd_pkg::DISP_LIMIT : mult10;

        item_next.net    = in_item.net;
        item_next.raw    = raw;
        item_next.rnd    = raw[23] ? -$signed(clamped) : $signed(clamped);
        item_next.above  = abs_net > {8'd0, cfg.min_trigger};
        item_next.stable = in_item.stable;
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

FILE: sv/swsd_update.sv
`default_nettype none

module swsd_update (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire swsd_pkg::cfg_t       cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire swsd_pkg::prep_item_t in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output swsd_pkg::out_item_t       out_item
);

    logic                valid_reg;
    logic                valid_next;
    swsd_pkg::out_item_t item_reg;
    swsd_pkg::out_item_t item_next;

    logic signed [23:0] net_reg;
    logic signed [23:0] net_next;
    logic signed [23:0] shown_reg;
    logic signed [23:0] shown_next;
    logic signed [23:0] display_reg;
    logic signed [23:0] display_next;
    logic               stable_reg;
    logic [7:0]         count_reg;
    logic [7:0]         count_next;
    logic               fired_reg;
    logic               fired_next;

    logic               take;
    logic               trig;
    logic               w_changed;
    logic [7:0]         count_inc;
    logic signed [24:0] delta;
    logic signed [25:0] upper;
    logic signed [25:0] lower;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb begin
        count_next = count_reg;
        fired_next = fired_reg;
        trig       = 1'b0;
        count_inc  = (count_reg != 8'hFF) ? count_reg + 8'd1 : count_reg;
        if (!in_item.stable) begin
            count_next = '0;
            fired_next = 1'b0;
        end else if (!fired_reg) begin
            if (in_item.above) begin
                count_next = count_inc;
                if (count_inc >= cfg.stable_needed) begin
                    trig       = 1'b1;
                    fired_next = 1'b1;
                end
            end else begin
                count_next = '0;
            end
        end

        delta     = 25'(in_item.net) - 25'(net_reg);
        w_changed = (delta > 25'sd1) || (delta < -25'sd1);
        upper     = 26'(display_reg) + $signed({16'd0, cfg.hysteresis});
        lower     = 26'(display_reg) - $signed({16'd0, cfg.hysteresis});

        net_next     = net_reg;
        shown_next   = shown_reg;
        display_next = display_reg;
        if (w_changed) begin
            net_next   = in_item.net;
            shown_next = in_item.raw;
            if (in_item.rnd > display_reg) begin
                if (26'(in_item.raw) > upper) begin
                    display_next = in_item.rnd;
                end
            end else if (in_item.rnd < display_reg) begin
                if (26'(in_item.raw) < lower) begin
                    display_next = in_item.rnd;
                end
            end
        end

        item_next.net_weight      = net_next;
        item_next.shown_weight    = shown_next;
        item_next.display_weight  = display_next;
        item_next.stable          = in_item.stable;
        item_next.stable_changed  = in_item.stable != stable_reg;
        item_next.trigger         = trig;
        item_next.weight_changed  = w_changed;
        item_next.display_changed = display_next != display_reg;

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            net_reg     <= '0;
            shown_reg   <= '0;
            display_reg <= '0;
            stable_reg  <= 1'b0;
            count_reg   <= '0;
            fired_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (take) begin
                net_reg     <= net_next;
                shown_reg   <= shown_next;
                display_reg <= display_next;
                stable_reg  <= in_item.stable;
                count_reg   <= count_next;
                fired_reg   <= fired_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

FILE: sv/scale_weight_stability_display.sv
// Scale sample conditioning: net weight, stability trigger and display value.
//
// The s_ channel carries one sensor sample per transaction; the m_ channel
// returns exactly one result transaction for each sample, in order. The cfg_
// channel writes the zero offset, tare, trigger threshold, needed stable count
// and display hysteresis; cfg_ready is always high and writes to unused
// indexes are dropped. The user must change configuration only while no sample
// is in flight; the block itself does not enforce this.
//
// The block is a three-stage pipeline: net weight subtraction and saturation,
// then shown-value clamping and rounding to 10 g, then the state update that
// drives the result register. Each sample passes the net, rounding and result
// registers in order; one sample is accepted per cycle while m_tready is high.
//
// When the receiver holds m_tready low, each stage keeps its transaction and
// the stall reaches s_tready once every stage is full; no transaction is lost.
// Reset clears the pipeline, the stored net and display weights, the stable
// counter and the configuration to its default values.

`default_nettype none

module scale_weight_stability_display (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // raw weight[23:0], status[39:24]
    input  wire logic [39:0]                  s_tdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // net weight[23:0], shown weight[47:24], display weight[71:48],
    // stable[72], stable_changed[73], trigger[74], weight_changed[75],
    // display_changed[76], zero fill[79:77]
    output logic [79:0]                       m_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [swsd_pkg::CfgIdxW-1:0] cfg_addr,
    input  wire logic [23:0]                  cfg_wdata
);

    swsd_pkg::cfg_t       cfg;
    swsd_pkg::net_item_t  net_item;
    swsd_pkg::prep_item_t prep_item;
    swsd_pkg::out_item_t  result;
    logic                 net_valid;
    logic                 net_ready;
    logic                 prep_valid;
    logic                 prep_ready;

    assign cfg_ready = 1'b1;

    swsd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_addr (cfg_addr),
        .wr_data (cfg_wdata),
        .cfg     (cfg)
    );

    swsd_net u_net (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .weight    ($signed(s_tdata[23:0])),
        .stable    (s_tdata[24]),
        .out_valid (net_valid),
        .out_ready (net_ready),
        .out_item  (net_item)
    );

    swsd_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (net_valid),
        .in_ready  (net_ready),
        .in_item   (net_item),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_item  (prep_item)
    );

    swsd_update u_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_item   (prep_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (result)
    );

    assign m_tdata = {3'b000,
                      result.display_changed,
                      result.weight_changed,
                      result.trigger,
                      result.stable_changed,
                      result.stable,
                      result.display_weight,
                      result.shown_weight,
                      result.net_weight};

    `include "scale_weight_stability_display_macros.svh"

    `SWSD_ASSERT(a_trigger_needs_stable, aclk, aresetn, m_tvalid && m_tdata[74] |-> m_tdata[72], "trigger without stable flag")
    `SWSD_ASSERT(a_display_needs_weight, aclk, aresetn, m_tvalid && m_tdata[76] |-> m_tdata[75], "display moved without net update")
    `SWSD_ASSERT(a_update_fill_order, aclk, aresetn, prep_valid && !prep_ready |-> m_tvalid, "update stage stalled while result empty")
    `SWSD_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid && !net_valid && !prep_valid, "pipeline not empty after reset")

endmodule

`default_nettype wire

FILE: tb/scale_weight_checker.sv
module scale_weight_checker
    import swsd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [39:0]        s_tdata,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [79:0]        m_tdata,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [CfgIdxW-1:0] cfg_addr,
    input  wire logic [23:0]        cfg_wdata,
    output int                      readings_due,
    output int                      bad_readings
);

    int         zero_g;
    int         tare_g;
    int         min_weight;
    logic [7:0] need_count;
    int         hyst_g;

    int         net_held;
    int         display_held;
    logic       stable_seen;
    logic [7:0] stable_run;
    logic       trigger_done;

    out_item_t  expected_readings[$];
    int         fail_count;

    function automatic int shown_of_net(input int n);
        return (n > -20 && n < 0) ? 0 : n;
    endfunction

    function automatic int round_to_ten(input int v);
        int mag;
        mag = (v < 0) ? -v : v;
        mag = ((mag + 5) / 10) * 10;
        if (mag > int'(DISP_LIMIT)) mag = int'(DISP_LIMIT);
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic out_item_t weigh_sample(input logic [23:0] raw_w,
                                               input logic [15:0] status);
        longint    diff;
        int        net;
        int        mag;
        int        shown;
        int        rounded;
        int        next_disp;
        logic      st;
        out_item_t r;
        r = '0;
        diff = longint'(signed'(raw_w)) - longint'(zero_g) - longint'(tare_g);
        if (diff > longint'(NET_MAX)) diff = longint'(NET_MAX);
        if (diff < longint'(NET_MIN)) diff = longint'(NET_MIN);
        net = int'(diff);

        st = status[0];
        r.stable = st;
        r.stable_changed = (st != stable_seen);
        stable_seen = st;
        if (!st) begin
            stable_run = '0;
            trigger_done = 1'b0;
        end
        if (st && !trigger_done) begin
            mag = (net < 0) ? -net : net;
            if (mag > min_weight) begin
                if (stable_run != 8'hFF) stable_run = stable_run + 8'd1;
                if (stable_run >= need_count) begin
                    r.trigger = 1'b1;
                    trigger_done = 1'b1;
                end
            end else begin
                stable_run = '0;
            end
        end

        mag = net - net_held;
        if (mag > 1 || mag < -1) begin
            r.weight_changed = 1'b1;
            net_held = net;
            shown = shown_of_net(net);
            rounded = round_to_ten(shown);
            next_disp = display_held;
            if (rounded > display_held) begin
                if (shown > display_held + hyst_g) next_disp = rounded;
            end else if (rounded < display_held) begin
                if (shown < display_held - hyst_g) next_disp = rounded;
            end
            if (next_disp != display_held) begin
                display_held = next_disp;
                r.display_changed = 1'b1;
            end
        end

        r.net_weight = 24'(net_held);
        r.shown_weight = 24'(shown_of_net(net_held));
        r.display_weight = 24'(display_held);
        return r;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        out_item_t got;
        if (!aresetn) begin
            zero_g = 0;
            tare_g = 0;
            min_weight = int'(MIN_TRIGGER_RESET);
            need_count = STABLE_NEEDED_RESET;
            hyst_g = int'(HYSTERESIS_RESET);
            net_held = 0;
            display_held = 0;
            stable_seen = 1'b0;
            stable_run = '0;
            trigger_done = 1'b0;
            expected_readings.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    CFG_ZERO_OFFSET:   zero_g = int'(signed'(cfg_wdata));
                    CFG_TARE:          tare_g = int'(signed'(cfg_wdata));
                    CFG_MIN_TRIGGER:   min_weight = int'(cfg_wdata[15:0]);
                    CFG_STABLE_NEEDED: need_count = cfg_wdata[7:0];
                    CFG_HYSTERESIS:    hyst_g = int'(cfg_wdata[9:0]);
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.net_weight      = m_tdata[23:0];
                got.shown_weight    = m_tdata[47:24];
                got.display_weight  = m_tdata[71:48];
                got.stable          = m_tdata[72];
                got.stable_changed  = m_tdata[73];
                got.trigger         = m_tdata[74];
                got.weight_changed  = m_tdata[75];
                got.display_changed = m_tdata[76];
                if (expected_readings.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected reading: net %0d shown %0d display %0d flags %b",
                                 got.net_weight, got.shown_weight, got.display_weight,
                                 got[4:0]);
                    end
                end else begin
                    want = expected_readings.pop_front();
                    if (got.net_weight !== want.net_weight ||
                        got.shown_weight !== want.shown_weight ||
                        got.display_weight !== want.display_weight ||
                        got.stable !== want.stable ||
                        got.stable_changed !== want.stable_changed ||
                        got.trigger !== want.trigger ||
                        got.weight_changed !== want.weight_changed ||
                        got.display_changed !== want.display_changed) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("reading mismatch: expected net %0d shown %0d display %0d flags %b, got net %0d shown %0d display %0d flags %b",
                                     want.net_weight, want.shown_weight, want.display_weight,
                                     want[4:0], got.net_weight, got.shown_weight,
                                     got.display_weight, got[4:0]);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_readings.push_back(weigh_sample(s_tdata[23:0], s_tdata[39:24]));
            end
        end
        readings_due <= expected_readings.size();
        bad_readings <= fail_count;
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    import swsd_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic [39:0]        s_tdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [79:0]        m_tdata;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CfgIdxW-1:0] cfg_addr = '0;
    logic [23:0]        cfg_wdata = '0;

    int readings_due;
    int bad_readings;
    int idle_pct = 0;
    int sink_hold = 0;

    always #4 aclk = ~aclk;

    scale_weight_stability_display u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    scale_weight_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .readings_due (readings_due),
        .bad_readings (bad_readings)
    );

    // The receiver drops m_tready in random bursts while idle_pct is nonzero.
    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            m_tready <= 1'b0;
            sink_hold--;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            m_tready <= 1'b0;
            sink_hold = $urandom_range(0, 16);
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_sample(input logic [23:0] weight, input logic [15:0] status);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tdata <= {status, weight};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_readings(input int settle);
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (readings_due != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [23:0] value);
        cfg_addr <= idx;
        cfg_wdata <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [23:0] zero, input logic [23:0] tare,
                                  input logic [15:0] min_g, input logic [7:0] needed,
                                  input logic [9:0] hyst);
        drain_readings(4);
        write_reg(CFG_ZERO_OFFSET, zero);
        write_reg(CFG_TARE, tare);
        write_reg(CFG_MIN_TRIGGER, {8'd0, min_g});
        write_reg(CFG_STABLE_NEEDED, {16'd0, needed});
        write_reg(CFG_HYSTERESIS, {14'd0, hyst});
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_settings();
        logic [23:0] zero;
        logic [23:0] tare;
        if ($urandom_range(0, 2) == 0) begin
            zero = 24'($urandom);
            tare = 24'($urandom);
        end else begin
            zero = 24'(int'($urandom_range(0, 400)) - 200);
            tare = 24'(int'($urandom_range(0, 1000)) - 500);
        end
        apply_settings(zero, tare,
                       ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 400)),
                       8'($urandom_range(1, 8)),
                       $urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, 20)));
    endtask

    // Mostly settling runs: an unstable sample, then stable samples drifting a few
    // grams around a base weight with an occasional step; the rest is noise.
    task automatic random_samples(input int count);
        int          left;
        int          run;
        int          base;
        logic [15:0] status;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 9) < 7) begin
                base = ($urandom_range(0, 3) == 0) ? (int'($urandom) >>> 8)
                                                   : int'($urandom_range(0, 4000)) - 2000;
                run = $urandom_range(2, 14);
                for (int k = 0; k < run && left > 0; k++) begin
                    status = 16'($urandom);
                    status[0] = (k != 0);
                    if ($urandom_range(0, 5) == 0) base += int'($urandom_range(0, 60)) - 30;
                    else base += int'($urandom_range(0, 8)) - 4;
                    send_sample(24'(base), status);
                    left--;
                end
            end else begin
                send_sample(24'($urandom), 16'($urandom));
                left--;
            end
        end
    endtask

    initial begin
        logic [23:0] seq_w[20] = '{24'd0, 24'd1000, 24'd1001, 24'd1003, 24'd1006, 24'd1009,
                                   24'd1005, 24'd1000, 24'd100, -24'sd5, -24'sd19, -24'sd20,
                                   -24'sd21, -24'sd155, -24'sd160, -24'sd165, 24'h7FFFFF,
                                   24'h800000, -24'sd8388605, 24'd15};
        logic [15:0] seq_s[20] = '{16'h0000, 16'h0001, 16'h0001, 16'hFFFF, 16'h0001,
                                   16'h0001, 16'hFFFE, 16'h0001, 16'h0001, 16'h0001,
                                   16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0001,
                                   16'h0001, 16'h8000, 16'h0001, 16'h0001, 16'h0001};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 20; i++) send_sample(seq_w[i], seq_s[i]);

        apply_settings(24'h800000, 24'h800000, 16'd0, 8'd1, 10'd0);
        send_sample(24'h7FFFFF, 16'h0001);
        send_sample(24'h800000, 16'h0001);
        send_sample(24'd0, 16'h0000);
        idle_pct = 10;
        random_samples(40);

        // Every net weight lands at or near the negative limit here, so a long
        // stable run reaches the largest needed count.
        apply_settings(24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 8'd255, 10'd1000);
        idle_pct = 30;
        send_sample(24'h800000, 16'h0000);
        for (int i = 0; i < 258; i++) send_sample(24'($urandom), {15'($urandom), 1'b1});

        apply_settings(24'(int'($urandom_range(0, 200)) - 100),
                       24'(int'($urandom_range(0, 200)) - 100),
                       16'($urandom_range(0, 300)), 8'd0, 10'($urandom_range(0, 20)));
        idle_pct = 0;
        random_samples(50);
        idle_pct = 20;
        random_samples(50);

        for (int p = 0; p < 3; p++) begin
            random_settings();
            idle_pct = (p == 1) ? 0 : 25;
            random_samples(50);
        end

        random_settings();
        idle_pct = 0;
        random_samples(80);

        drain_readings(10);
        if (bad_readings == 0 && readings_due == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
